@@ hdl/ne2u_pkg.sv @@
// Shared types and constants for the numeric entity to UTF-8 converter.
package ne2u_pkg;

	localparam int NE2U_QUEUE_DEPTH = 4;

	localparam logic [7:0]  CH_HASH    = 8'h23;
	localparam logic [7:0]  CH_X_UPPER = 8'h58;
	localparam logic [7:0]  CH_X_LOWER = 8'h78;
	localparam logic [1:0]  POS_FULL   = 2'd3;

	localparam logic [31:0] CP_MAX_1B  = 32'h0000_007F;
	localparam logic [31:0] CP_MAX_2B  = 32'h0000_07FF;
	localparam logic [31:0] CP_MAX_3B  = 32'h0000_FFFF;
	localparam logic [31:0] CP_MAX     = 32'h0010_FFFF;

	localparam logic [7:0]  LEAD_2B    = 8'hC0;
	localparam logic [7:0]  LEAD_3B    = 8'hE0;
	localparam logic [7:0]  LEAD_4B    = 8'hF0;
	localparam logic [7:0]  CONT_MARK  = 8'h80;
	localparam logic [7:0]  REPL_B0    = 8'hEF;
	localparam logic [7:0]  REPL_B1    = 8'hBF;
	localparam logic [7:0]  REPL_B2    = 8'hBD;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       not_numeric;
	} out_item_t;

	// One finished entity, handed from the front to the back.
	typedef struct packed {
		logic [31:0] code_point;
		logic        is_numeric;
	} entity_t;

	typedef struct packed {
		logic    valid;
		entity_t ent;
	} entity_push_t;

endpackage

@@ hdl/numeric_entity_to_utf8_core.sv @@
// Top level of the numeric character reference to UTF-8 converter.
//
// Usage: feed the bytes of one entity, from the ampersand through the closing
// byte, one item per cycle on the item channel, with is_last set on the
// closing byte. Nothing comes out for the other bytes. For the closing byte
// the result channel delivers 1 to 4 UTF-8 bytes, EF BF BD for a code point of
// zero or beyond U+10FFFF, or a single marker item with not_numeric set when
// the entity is not a numeric reference. last_of_run marks the final item.
// One input item per cycle; results leave at one per cycle while result_ready
// is high. An entity crosses the queue, current-entity register and output
// register before its first result is valid. A queue of QUEUE_DEPTH finished
// entities parts the byte front end from the encoder, so the input keeps
// flowing while the encoder spells out a multi-byte run; item_ready drops
// only when that queue is full, which happens when the receiver stalls long
// enough. Reset clears the position, mode flags, accumulator, queue and
// output register; the block is ready as soon as reset is released.
module numeric_entity_to_utf8_core import ne2u_pkg::*; #(
	parameter int QUEUE_DEPTH = NE2U_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	entity_push_t push;
	logic         queue_full;
	logic         head_valid;
	entity_t      head;
	logic         pop;

	// Front: classify bytes and accumulate the code point.
	ne2u_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.queue_full (queue_full),
		.push       (push)
	);

	// Hold finished entities until the encoder is free.
	ne2u_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head       (head)
	);

	// Back: encode and emit one byte per cycle while result_ready is high.
	ne2u_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

@@ hdl/ne2u_front.sv @@
// Front end: accepts entity bytes, tracks position and mode, accumulates the code point.
module ne2u_front import ne2u_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_ready,
	input  in_item_t     item,
	input  logic         queue_full,
	output entity_push_t push
);

	logic [1:0]  pos_q;
	logic        numeric_q;
	logic        hex_q;
	logic [31:0] acc_q;
	logic        accept;
	logic        is_x;
	logic [31:0] byte_ext;
	logic [31:0] dec_next;
	logic [31:0] hex_next;
	logic [31:0] hex_digit;

	assign item_ready = !queue_full;
	assign accept     = item_valid && item_ready;
	assign byte_ext   = {24'd0, item.text_byte};
	assign is_x       = (item.text_byte == CH_X_LOWER) || (item.text_byte == CH_X_UPPER);

	always_comb begin
		if (item.text_byte >= 8'h30 && item.text_byte <= 8'h39) begin
			hex_digit = byte_ext - 32'h30;
		end else if (item.text_byte >= 8'h41 && item.text_byte <= 8'h5A) begin
			hex_digit = byte_ext - 32'h37;
		end else begin
			hex_digit = byte_ext - 32'h57;
		end
	end

	assign dec_next = (acc_q << 3) + (acc_q << 1) + (byte_ext - 32'h30);
	assign hex_next = (acc_q << 4) + hex_digit;

	assign push.valid          = accept && item.is_last;
	assign push.ent.code_point = acc_q;
	assign push.ent.is_numeric = (pos_q == POS_FULL) && numeric_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 2'd0;
			numeric_q <= 1'b0;
			hex_q     <= 1'b0;
			acc_q     <= 32'd0;
		end else if (accept) begin
			if (item.is_last) begin
				pos_q     <= 2'd0;
				numeric_q <= 1'b0;
				hex_q     <= 1'b0;
				acc_q     <= 32'd0;
			end else begin
				unique case (pos_q)
					2'd1: begin
						numeric_q <= (item.text_byte == CH_HASH);
					end
					2'd2: begin
						hex_q <= is_x;
						if (!is_x) begin
							acc_q <= dec_next;
						end
					end
					2'd3: begin
						acc_q <= hex_q ? hex_next : dec_next;
					end
					default: begin
					end
				endcase
				if (pos_q != POS_FULL) begin
					pos_q <= pos_q + 2'd1;
				end
			end
		end
	end

endmodule

@@ hdl/ne2u_queue.sv @@
// Small FIFO of finished entities between the front and the back.
module ne2u_queue import ne2u_pkg::*; #(
	parameter int DEPTH = NE2U_QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  entity_push_t push,
	input  logic         pop,
	output logic         full,
	output logic         head_valid,
	output entity_t      head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	entity_t       slots_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_pop;

	assign full       = (cnt_q == FULL_CNT);
	assign head_valid = (cnt_q != '0);
	assign head       = slots_q[rd_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slots_q[wr_q] <= push.ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= (wr_q == LAST_SLOT) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_SLOT) ? '0 : rd_q + PW'(1);
			end
			if (push.valid && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !push.valid) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

@@ hdl/ne2u_back.sv @@
// Back end: encodes one entity as UTF-8, a byte per cycle unless stalled.
module ne2u_back import ne2u_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  entity_t   head,
	output logic      pop,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	logic [7:0]  enc_b [4];
	logic [1:0]  enc_n;
	logic [31:0] cp;

	logic [7:0]  bytes_q [4];
	logic [1:0]  n_q;
	logic [1:0]  idx_q;
	logic        marker_q;
	logic        cur_valid_q;
	logic        res_valid_q;
	out_item_t   res_q;

	logic        out_free;
	logic        emit;
	logic        cur_done;

	assign cp = head.code_point;

	// Encode the queue head; enc_n is the index of its last byte.
	always_comb begin
		enc_b[0] = 8'd0;
		enc_b[1] = 8'd0;
		enc_b[2] = 8'd0;
		enc_b[3] = 8'd0;
		enc_n    = 2'd0;
		if (!head.is_numeric) begin
			enc_n = 2'd0;
		end else if (cp == 32'd0 || cp > CP_MAX) begin
			enc_b[0] = REPL_B0;
			enc_b[1] = REPL_B1;
			enc_b[2] = REPL_B2;
			enc_n    = 2'd2;
		end else if (cp <= CP_MAX_1B) begin
			enc_b[0] = cp[7:0];
		end else if (cp <= CP_MAX_2B) begin
			enc_b[0] = LEAD_2B | {3'd0, cp[10:6]};
			enc_b[1] = CONT_MARK | {2'd0, cp[5:0]};
			enc_n    = 2'd1;
		end else if (cp <= CP_MAX_3B) begin
			enc_b[0] = LEAD_3B | {4'd0, cp[15:12]};
			enc_b[1] = CONT_MARK | {2'd0, cp[11:6]};
			enc_b[2] = CONT_MARK | {2'd0, cp[5:0]};
			enc_n    = 2'd2;
		end else begin
			enc_b[0] = LEAD_4B | {5'd0, cp[20:18]};
			enc_b[1] = CONT_MARK | {2'd0, cp[17:12]};
			enc_b[2] = CONT_MARK | {2'd0, cp[11:6]};
			enc_b[3] = CONT_MARK | {2'd0, cp[5:0]};
			enc_n    = 2'd3;
		end
	end

	assign out_free     = !res_valid_q || result_ready;
	assign emit         = cur_valid_q && out_free;
	assign cur_done     = emit && (idx_q == n_q);
	assign pop          = head_valid && (!cur_valid_q || cur_done);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			bytes_q  <= enc_b;
			n_q      <= enc_n;
			marker_q <= !head.is_numeric;
		end
		if (emit) begin
			res_q.out_byte    <= bytes_q[idx_q];
			res_q.last_of_run <= (idx_q == n_q);
			res_q.not_numeric <= marker_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= 2'd0;
			end else if (cur_done) begin
				cur_valid_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 2'd1;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ bench/numeric_entity_to_utf8_core_test.sv @@
// Self-checking testbench for the numeric character reference to UTF-8 converter core.
module numeric_entity_to_utf8_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ne2u_pkg::*;

	localparam int ITEM_TARGET      = 470;   // at least this many bytes of entity text to send
	localparam int IDLE_LIMIT       = 5000;  // cycles with no handshake before giving up
	localparam int DRAIN_CYCLES     = 20;    // settle time after the last result
	localparam int HOLDOFF_AFTER    = 60;    // results to see before the long stall
	localparam int HOLDOFF_CYCLES   = 400;
	localparam int SHOWN_MISMATCHES = 10;

	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_A_UPPER = 8'h41;
	localparam logic [7:0] CH_Z_UPPER = 8'h5A;
	localparam logic [7:0] CH_A_LOWER = 8'h61;
	localparam logic [7:0] CH_Z_LOWER = 8'h7A;

	// Code points at an encoding boundary, at the surrogate range edges, or past the valid range.
	localparam logic [31:0] CORNER_CP [13] = '{
		32'h0000_0000, 32'h0000_0001, 32'h0000_007F, 32'h0000_0080, 32'h0000_07FF,
		32'h0000_0800, 32'h0000_D800, 32'h0000_DFFF, 32'h0000_FFFF, 32'h0001_0000,
		32'h0010_FFFF, 32'h0011_0000, 32'hFFFF_FFFF
	};

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_COMB, RX_SLOW} rx_mode_e;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      item_valid   = 1'b0;
	logic      item_ready;
	in_item_t  item         = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	out_item_t result;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	numeric_entity_to_utf8_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// ------------------------------------------------------------------
	// Entity decoder model: position, mode flags and code point in flight,
	// plus the UTF-8 bytes still owed by the block, oldest first.
	// ------------------------------------------------------------------
	logic [1:0]  ent_pos     = 2'd0;
	logic        ent_numeric = 1'b0;
	logic        ent_hex     = 1'b0;
	logic [31:0] code_acc    = 32'd0;
	out_item_t   utf8_expected[$];

	function automatic void owe_byte(logic [7:0] b, logic last, logic marker);
		out_item_t e;
		e.out_byte    = b;
		e.last_of_run = last;
		e.not_numeric = marker;
		utf8_expected.push_back(e);
	endfunction

	// Spell a code point as UTF-8; zero and anything past U+10FFFF become U+FFFD.
	function automatic void spell_utf8(logic [31:0] cp);
		if (cp == 32'd0 || cp > CP_MAX) begin
			owe_byte(REPL_B0, 1'b0, 1'b0);
			owe_byte(REPL_B1, 1'b0, 1'b0);
			owe_byte(REPL_B2, 1'b1, 1'b0);
		end else if (cp <= CP_MAX_1B) begin
			owe_byte(cp[7:0], 1'b1, 1'b0);
		end else if (cp <= CP_MAX_2B) begin
			owe_byte(LEAD_2B | {3'b0, cp[10:6]}, 1'b0, 1'b0);
			owe_byte(CONT_MARK | {2'b0, cp[5:0]}, 1'b1, 1'b0);
		end else if (cp <= CP_MAX_3B) begin
			// surrogates land here too, spelled like any other BMP value
			owe_byte(LEAD_3B | {4'b0, cp[15:12]}, 1'b0, 1'b0);
			owe_byte(CONT_MARK | {2'b0, cp[11:6]}, 1'b0, 1'b0);
			owe_byte(CONT_MARK | {2'b0, cp[5:0]}, 1'b1, 1'b0);
		end else begin
			owe_byte(LEAD_4B | {5'b0, cp[20:18]}, 1'b0, 1'b0);
			owe_byte(CONT_MARK | {2'b0, cp[17:12]}, 1'b0, 1'b0);
			owe_byte(CONT_MARK | {2'b0, cp[11:6]}, 1'b0, 1'b0);
			owe_byte(CONT_MARK | {2'b0, cp[5:0]}, 1'b1, 1'b0);
		end
	endfunction

	// Weight of one digit byte; bytes that are no digit still count, wrapping mod 2^32.
	function automatic logic [31:0] digit_weight(logic [7:0] b, logic hex);
		logic [31:0] w;
		w = {24'b0, b};
		if (!hex || (b >= CH_ZERO && b <= CH_NINE))
			return w - 32'(CH_ZERO);
		if (b >= CH_A_UPPER && b <= CH_Z_UPPER)
			return w - 32'(CH_A_UPPER) + 32'd10;
		return w - 32'(CH_A_LOWER) + 32'd10;
	endfunction

	// Advance the decoder by one accepted byte and owe whatever it produces.
	function automatic void absorb_entity_byte(in_item_t it);
		if (it.is_last) begin
			if (ent_pos == POS_FULL && ent_numeric)
				spell_utf8(code_acc);
			else
				owe_byte(8'h00, 1'b1, 1'b1);
			ent_pos     = 2'd0;
			ent_numeric = 1'b0;
			ent_hex     = 1'b0;
			code_acc    = 32'd0;
		end else begin
			case (ent_pos)
				2'd1: begin
					ent_numeric = (it.text_byte == CH_HASH);
				end
				2'd2: begin
					ent_hex = (it.text_byte == CH_X_LOWER || it.text_byte == CH_X_UPPER);
					if (!ent_hex)
						code_acc = code_acc * 32'd10 + digit_weight(it.text_byte, 1'b0);
				end
				POS_FULL: begin
					if (ent_hex)
						code_acc = code_acc * 32'd16 + digit_weight(it.text_byte, 1'b1);
					else
						code_acc = code_acc * 32'd10 + digit_weight(it.text_byte, 1'b0);
				end
				default: begin
				end
			endcase
			if (ent_pos != POS_FULL)
				ent_pos = ent_pos + 2'd1;
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus: entity text is assembled in entity_text, then flushed into
	// text_stream as items with the closing byte marked last.
	// ------------------------------------------------------------------
	in_item_t   text_stream[$];
	logic [7:0] entity_text[$];

	function automatic void flush_entity(logic [7:0] close);
		in_item_t it;
		foreach (entity_text[i]) begin
			it.text_byte = entity_text[i];
			it.is_last   = 1'b0;
			text_stream.push_back(it);
		end
		it.text_byte = close;
		it.is_last   = 1'b1;
		text_stream.push_back(it);
		entity_text.delete();
	endfunction

	function automatic void append_decimal(logic [31:0] cp);
		logic [31:0] v;
		int          at;
		v  = cp;
		at = entity_text.size();
		do begin
			entity_text.insert(at, 8'(32'(CH_ZERO) + v % 32'd10));
			v = v / 32'd10;
		end while (v != 32'd0);
	endfunction

	// Hex digits with the letter case picked per digit.
	function automatic void append_hex(logic [31:0] cp);
		logic [31:0] v;
		logic [7:0]  nib;
		int          at;
		v  = cp;
		at = entity_text.size();
		do begin
			nib = {4'b0, v[3:0]};
			if (nib < 8'd10)
				entity_text.insert(at, CH_ZERO + nib);
			else if ($urandom_range(0, 1) == 0)
				entity_text.insert(at, CH_A_UPPER + nib - 8'd10);
			else
				entity_text.insert(at, CH_A_LOWER + nib - 8'd10);
			v = v >> 4;
		end while (v != 32'd0);
	endfunction

	function automatic logic [31:0] pick_code_point();
		case ($urandom_range(0, 6))
			1:       return $urandom_range(32'h7F, 32'h1);
			2:       return $urandom_range(32'h7FF, 32'h80);
			3:       return $urandom_range(32'hFFFF, 32'h800);
			4:       return $urandom_range(32'h10FFFF, 32'h10000);
			5:       return $urandom_range(32'hFFFF_FFFF, 32'h110000);
			default: return CORNER_CP[$urandom_range(0, 12)];
		endcase
	endfunction

	function automatic logic [7:0] pick_close();
		return ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) : CH_SEMI;
	endfunction

	// Mostly well-formed references with random values; the rest is overflow,
	// garbage digits, named or short entities, and plain noise.
	function automatic void add_random_entity();
		int          kind;
		int          n;
		logic        hex;
		kind = $urandom_range(0, 99);
		hex  = 1'($urandom_range(0, 1));
		if (kind < 55) begin
			entity_text = '{CH_AMP, CH_HASH};
			if (hex)
				entity_text.push_back($urandom_range(0, 1) ? CH_X_LOWER : CH_X_UPPER);
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) entity_text.push_back(CH_ZERO);
			if (hex)
				append_hex(pick_code_point());
			else
				append_decimal(pick_code_point());
			flush_entity(pick_close());
		end else if (kind < 65) begin
			// far too many digits: the code point wraps mod 2^32
			entity_text = '{CH_AMP, CH_HASH};
			if (hex) begin
				entity_text.push_back(CH_X_UPPER);
				repeat ($urandom_range(9, 12)) append_hex(32'($urandom_range(0, 15)));
			end else begin
				repeat ($urandom_range(11, 14)) append_decimal(32'($urandom_range(0, 9)));
			end
			flush_entity(CH_SEMI);
		end else if (kind < 78) begin
			entity_text = '{CH_AMP, CH_HASH};
			if (hex)
				entity_text.push_back($urandom_range(0, 1) ? CH_X_LOWER : CH_X_UPPER);
			n = $urandom_range(1, 6);
			repeat (n) entity_text.push_back(8'($urandom_range(0, 255)));
			flush_entity(($urandom_range(0, 1) == 0) ? CH_SEMI : 8'($urandom_range(0, 255)));
		end else if (kind < 90) begin
			entity_text = '{CH_AMP};
			if ($urandom_range(0, 4) == 0)
				entity_text.push_back(CH_HASH);
			n = $urandom_range(0, 6);
			repeat (n) entity_text.push_back(8'($urandom_range(CH_Z_LOWER, CH_A_LOWER)));
			flush_entity(CH_SEMI);
		end else begin
			n = $urandom_range(0, 5);
			repeat (n) entity_text.push_back(8'($urandom_range(0, 255)));
			flush_entity(8'($urandom_range(0, 255)));
		end
	endfunction

	// ------------------------------------------------------------------
	// Sender: bursts of random length, random gaps between them, and some
	// back-to-back bursts with no gap at all.
	// ------------------------------------------------------------------
	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready)
				absorb_entity_byte(item);
			// hold valid and payload until the block takes the item
			if (!item_valid || item_ready) begin
				if (gap_left != 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (text_stream.size() != 0) begin
					item       <= text_stream.pop_front();
					item_valid <= 1'b1;
					if (burst_left == 0)
						burst_left = $urandom_range(1, 40);
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: check each taken result against the oldest owed byte, and
	// stall on a pattern that switches between modes every so often.
	// Once, well into the run, stop taking results for a long stretch so
	// the entity queue fills and the block has to drop item_ready.
	// ------------------------------------------------------------------
	rx_mode_e    rx_mode       = RX_OPEN;
	int unsigned mode_left     = 0;
	int unsigned rx_tick       = 0;
	int unsigned hold_left     = 0;
	bit          holdoff_done  = 1'b0;
	int unsigned results_seen  = 0;
	int unsigned failures      = 0;
	out_item_t   want_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			rx_tick++;
			if (result_valid && result_ready) begin
				results_seen++;
				if (utf8_expected.size() == 0) begin
					failures++;
					if (failures <= SHOWN_MISMATCHES)
						$display("%0t: result with nothing owed: byte %h last %b not_numeric %b",
							$realtime, result.out_byte, result.last_of_run, result.not_numeric);
				end else begin
					want_item = utf8_expected.pop_front();
					if (result.out_byte !== want_item.out_byte ||
							result.last_of_run !== want_item.last_of_run ||
							result.not_numeric !== want_item.not_numeric) begin
						failures++;
						if (failures <= SHOWN_MISMATCHES)
							$display("%0t: result %0d: expected %h/%b/%b, got %h/%b/%b",
								$realtime, results_seen, want_item.out_byte,
								want_item.last_of_run, want_item.not_numeric, result.out_byte,
								result.last_of_run, result.not_numeric);
					end
				end
			end

			if (hold_left != 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (!holdoff_done && results_seen >= HOLDOFF_AFTER) begin
				holdoff_done = 1'b1;
				hold_left    = HOLDOFF_CYCLES;
				result_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = rx_mode_e'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (rx_mode)
					RX_OPEN: result_ready <= 1'b1;
					RX_COIN: result_ready <= 1'($urandom_range(0, 1));
					RX_COMB: result_ready <= (rx_tick % 4 != 3);
					default: result_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: count cycles with no handshake on either side. A lost or
	// missing result leaves bytes owed forever and ends up here.
	// ------------------------------------------------------------------
	int unsigned idle_cycles = 0;

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence: build the text, release reset, wait for the drain.
	// ------------------------------------------------------------------
	initial begin
		// Decimal zero: replacement character.
		entity_text = '{CH_AMP, CH_HASH, CH_ZERO};
		flush_entity(CH_SEMI);
		// Top of the range in hex, mixed letter case: four bytes.
		entity_text = '{CH_AMP, CH_HASH, CH_X_LOWER, 8'h31, 8'h30, 8'h66, 8'h46, 8'h66, 8'h46};
		flush_entity(CH_SEMI);
		// Too short to be numeric: marker.
		entity_text = '{CH_AMP, CH_HASH};
		flush_entity(CH_SEMI);
		// A letter in decimal mode still adds its offset from '0'.
		entity_text = '{CH_AMP, CH_HASH, CH_A_LOWER};
		flush_entity(CH_SEMI);
		// A lone closing byte with nothing before it.
		flush_entity(8'h00);
		// No hash, all-ones bytes: marker.
		entity_text = '{CH_AMP, 8'hFF};
		flush_entity(8'hFF);

		while (text_stream.size() < ITEM_TARGET)
			add_random_entity();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Sample on the falling edge so the sender's updates have settled.
		while (text_stream.size() != 0 || item_valid || utf8_expected.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
